FILE: rtl/core/prc_pkg.sv
// Shared types, codes and helpers of the prefix route classifier.
// No dependencies; every other file imports this package.
package prc_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 6;
   localparam int IDX_W   = 4;
   localparam int TTL_W   = 8;
   localparam int CNT_W   = 32;
   localparam int CNT_NUM = 5;

   typedef enum logic [0:0] {
      REQ_WRITE = 1'b0,
      REQ_ROUTE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      DEST_DIRECT = 2'd0,
      DEST_HOP_B  = 2'd1,
      DEST_HOP_C  = 2'd2,
      DEST_OTHER  = 2'd3
   } dest_type;

   typedef enum logic [2:0] {
      V_EXPIRED    = 3'd0,
      V_UNROUTABLE = 3'd1,
      V_DIRECT     = 3'd2,
      V_HOP_B      = 3'd3,
      V_HOP_C      = 3'd4,
      V_OTHER      = 3'd5
   } verdict_type;

   typedef enum logic [2:0] {
      CNT_EXPIRED    = 3'd0,
      CNT_UNROUTABLE = 3'd1,
      CNT_DIRECT     = 3'd2,
      CNT_HOP_B      = 3'd3,
      CNT_HOP_C      = 3'd4
   } counter_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  length;
      dest_type          dest;
   } route_entry_type;

   typedef struct packed {
      logic            inc;
      counter_sel_type sel;
   } cnt_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] expired;
      logic [CNT_W-1:0] unroutable;
      logic [CNT_W-1:0] direct;
      logic [CNT_W-1:0] hop_b;
      logic [CNT_W-1:0] hop_c;
   } counts_type;

   typedef struct packed {
      logic [0:0]        req_type;
      logic [IDX_W-1:0]  entry_index;
      logic [ADDR_W-1:0] entry_prefix;
      logic [LEN_W-1:0]  entry_length;
      logic [1:0]        entry_dest;
      logic [0:0]        entry_valid;
      logic [ADDR_W-1:0] dest_addr;
      logic [TTL_W-1:0]  ttl_in;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]        verdict;
      logic [TTL_W-1:0]  ttl_out;
      logic [IDX_W-1:0]  match_index;
      logic [CNT_W-1:0]  expired_count;
      logic [CNT_W-1:0]  unroutable_count;
      logic [CNT_W-1:0]  direct_count;
      logic [CNT_W-1:0]  hop_b_count;
      logic [CNT_W-1:0]  hop_c_count;
   } rsp_payload_type;

   // leading-ones mask; lengths above the address width compare all bits
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] sh;
      sh = LEN_W'(ADDR_W) - len;
      if (len == '0) begin
         return '0;
      end
      if (len >= LEN_W'(ADDR_W)) begin
         return '1;
      end
      return {ADDR_W{1'b1}} << sh;
   endfunction

endpackage

FILE: rtl/core/prc_channels_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on prc_pkg for the payload structs.
interface prc_req_if import prc_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface prc_rsp_if import prc_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/prc_route_table.sv
// Route table: entry memory with registered read, valid bits in flops.
// Depends on prc_pkg.
module prc_route_table import prc_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int TIDX_W      = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [TIDX_W-1:0] wr_addr,
   input  route_entry_type   wr_entry,
   input  logic              wr_valid,
   input  logic [TIDX_W-1:0] rd_addr,
   output route_entry_type   rd_entry,
   output logic              rd_valid
);

   route_entry_type        mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   route_entry_type        rd_entry_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= wr_valid;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

FILE: rtl/core/prc_match_unit.sv
// Shared prefix compare: one table entry against the packet address.
// Depends on prc_pkg.
module prc_match_unit import prc_pkg::*; (
   input  logic [ADDR_W-1:0] addr,
   input  route_entry_type   entry,
   input  logic              entry_valid,
   output logic              hit
);

   logic [ADDR_W-1:0] mask;

   assign mask = prefix_mask(entry.length);
   assign hit  = entry_valid && ((addr & mask) == (entry.prefix & mask));

endmodule

FILE: rtl/core/prc_counters.sv
// Five saturating traffic counters behind one shared incrementer.
// Depends on prc_pkg.
module prc_counters import prc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cnt_cmd_type cmd,
   output counts_type  counts
);

   logic [CNT_W-1:0] cnt_ff [CNT_NUM];
   logic [CNT_W-1:0] cnt_in;

   always_comb begin
      cnt_in = (cnt_ff[cmd.sel] == '1) ? cnt_ff[cmd.sel] : cnt_ff[cmd.sel] + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CNT_NUM; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cmd.inc) begin
         cnt_ff[cmd.sel] <= cnt_in;
      end
   end

   assign counts.expired    = cnt_ff[CNT_EXPIRED];
   assign counts.unroutable = cnt_ff[CNT_UNROUTABLE];
   assign counts.direct     = cnt_ff[CNT_DIRECT];
   assign counts.hop_b      = cnt_ff[CNT_HOP_B];
   assign counts.hop_c      = cnt_ff[CNT_HOP_C];

endmodule

FILE: rtl/core/prefix_route_classifier_core.sv
// Top level of the prefix route classifier: sequencer, table, compare, counters.
// Depends on prc_pkg, prc_channels_if, prc_route_table, prc_match_unit, prc_counters.
//
//   channel    dir  modport  word
//   req_chan   in   sink     table write or packet to route
//   rsp_chan   out  source   verdict, ttl, match slot, five counters
//
// Sequence: a write word or an expired packet goes from accept straight to the
// response state, then back to idle. A routed packet scans the table from slot
// 0 up to the first matching slot, or through every slot when nothing matches,
// then responds; the single compare unit checks one entry per cycle, fed by the
// table's one registered read port.
// Reset: synchronous, active high; clears valid bits and counters, no sweep.
// Stalls: the response word holds until taken; req_chan is not ready meanwhile.
module prefix_route_classifier_core import prc_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   prc_req_if.sink   req_chan,
   prc_rsp_if.source rsp_chan
);

   localparam int TIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   state_type         state_ff, state_in;
   logic [TIDX_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [TTL_W-1:0]  ttl_ff, ttl_in;
   logic [IDX_W-1:0]  match_ff, match_in;
   verdict_type       verdict_ff, verdict_in;

   logic              accept;
   logic              is_write;
   logic              expired;
   logic              last_entry;
   logic              hit;
   logic              tbl_wr_en;
   route_entry_type   wr_entry;
   route_entry_type   rd_entry;
   logic              rd_valid;
   cnt_cmd_type       cnt_cmd;
   counts_type        counts;

   assign accept     = req_chan.valid && req_chan.ready;
   assign is_write   = (req_kind_type'(req_chan.data.req_type) == REQ_WRITE);
   assign expired    = (req_chan.data.ttl_in <= TTL_W'(1));
   assign last_entry = (ptr_ff == TIDX_W'(TABLE_DEPTH - 1));

   // slots beyond the table are acknowledged but dropped
   assign tbl_wr_en       = accept && is_write
                            && (32'(req_chan.data.entry_index) < TABLE_DEPTH);
   assign wr_entry.prefix = req_chan.data.entry_prefix;
   assign wr_entry.length = req_chan.data.entry_length;
   assign wr_entry.dest   = dest_type'(req_chan.data.entry_dest);

   prc_route_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIDX_W      (TIDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_addr  (TIDX_W'(req_chan.data.entry_index)),
      .wr_entry (wr_entry),
      .wr_valid (req_chan.data.entry_valid[0]),
      .rd_addr  (ptr_in),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid)
   );

   prc_match_unit u_match (
      .addr        (addr_ff),
      .entry       (rd_entry),
      .entry_valid (rd_valid),
      .hit         (hit)
   );

   prc_counters u_counters (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cnt_cmd),
      .counts (counts)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (is_write || expired) ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit || last_entry) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      ptr_in         = ptr_ff;
      addr_in        = addr_ff;
      ttl_in         = ttl_ff;
      match_in       = match_ff;
      verdict_in     = verdict_ff;
      cnt_cmd.inc    = 1'b0;
      cnt_cmd.sel    = CNT_EXPIRED;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            ptr_in         = '0;
            if (accept) begin
               addr_in  = req_chan.data.dest_addr;
               match_in = '0;
               ttl_in   = '0;
               if (is_write) begin
                  verdict_in = V_OTHER;
               end else if (expired) begin
                  verdict_in  = V_EXPIRED;
                  cnt_cmd.inc = 1'b1;
                  cnt_cmd.sel = CNT_EXPIRED;
               end else begin
                  ttl_in = req_chan.data.ttl_in - TTL_W'(1);
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               match_in = IDX_W'(ptr_ff);
               case (rd_entry.dest)
                  DEST_DIRECT: begin
                     verdict_in  = V_DIRECT;
                     cnt_cmd.inc = 1'b1;
                     cnt_cmd.sel = CNT_DIRECT;
                  end
                  DEST_HOP_B: begin
                     verdict_in  = V_HOP_B;
                     cnt_cmd.inc = 1'b1;
                     cnt_cmd.sel = CNT_HOP_B;
                  end
                  DEST_HOP_C: begin
                     verdict_in  = V_HOP_C;
                     cnt_cmd.inc = 1'b1;
                     cnt_cmd.sel = CNT_HOP_C;
                  end
                  default: verdict_in = V_OTHER;
               endcase
            end else if (last_entry) begin
               match_in    = '0;
               verdict_in  = V_UNROUTABLE;
               cnt_cmd.inc = 1'b1;
               cnt_cmd.sel = CNT_UNROUTABLE;
            end else begin
               ptr_in = ptr_ff + TIDX_W'(1);
            end
         end
         ST_RESP: begin
            rsp_chan.valid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      ttl_ff     <= ttl_in;
      match_ff   <= match_in;
      verdict_ff <= verdict_in;
   end

   assign rsp_chan.data.verdict          = verdict_ff;
   assign rsp_chan.data.ttl_out          = ttl_ff;
   assign rsp_chan.data.match_index      = match_ff;
   assign rsp_chan.data.expired_count    = counts.expired;
   assign rsp_chan.data.unroutable_count = counts.unroutable;
   assign rsp_chan.data.direct_count     = counts.direct;
   assign rsp_chan.data.hop_b_count      = counts.hop_b;
   assign rsp_chan.data.hop_c_count      = counts.hop_c;

   // one word in flight: never ready while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request taken while response pending");

   // counters move only on the way into the response state
   a_cnt_then_resp: assert property (@(posedge clock) disable iff (reset)
      cnt_cmd.inc |=> (state_ff == ST_RESP))
      else $error("counter bumped outside of item completion");

   // scan pointer stays inside the table
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(ptr_ff) < TABLE_DEPTH))
      else $error("scan pointer beyond table");

   // expired packets carry no ttl (acks get a zero ttl as well)
   a_expired_ttl: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (verdict_ff == V_EXPIRED)) |-> (rsp_chan.data.ttl_out == '0))
      else $error("expired verdict with nonzero ttl");

endmodule
